### rtl/core/bdq_pkg.sv
// Package for the bounded deque: operation codes, per-beat command bundle
// and shared widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int WORD_W           = 32;
  localparam int MODE_W           = 3;
  localparam int COUNT_W          = 5;
  localparam int DEFAULT_CAPACITY = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_CLEAR      = 3'd4
  } mode_t;

  // One-hot command broadcast to every cell; all zero means hold.
  typedef struct packed {
    logic add_back;
    logic add_front;
    logic take_back;
    logic take_front;
    logic clear;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/bdq_cell.sv
// One storage cell of the deque chain: a word plus an occupied bit.
// Shifts toward either neighbor on front operations. Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell
  import bdq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  input  wire logic signed [WORD_W-1:0] value,
  input  wire logic signed [WORD_W-1:0] left_data,
  input  wire logic                     left_occ,
  input  wire logic signed [WORD_W-1:0] right_data,
  input  wire logic                     right_occ,
  output logic signed [WORD_W-1:0]      data,
  output logic                          occ
);

  logic signed [WORD_W-1:0] data_next;
  logic                     occ_next;

  always_comb begin
    data_next = data;
    occ_next  = occ;
    if (cmd.add_front) begin
      data_next = left_data;
      occ_next  = left_occ;
    end else if (cmd.take_front) begin
      data_next = right_data;
      occ_next  = right_occ;
    end else if (cmd.add_back) begin
      // first free cell behind the occupied run takes the word
      if (!occ && left_occ) begin
        data_next = value;
        occ_next  = 1'b1;
      end
    end else if (cmd.take_back) begin
      if (occ && !right_occ) begin
        occ_next = 1'b0;
      end
    end else if (cmd.clear) begin
      occ_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bounded_deque.sv
// Top level of the bounded deque: stream ports, command decode, count,
// the cell chain and the result register. Depends on bdq_pkg and bdq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of signed 32-bit words.
// Input channel s_*: one beat per operation (mode, value). Output channel
// m_*: one beat per operation with front and back words, count, empty flag
// and error flag as they stand after the operation.
// Elements live in a chain of CAPACITY cells packed from cell 0 (front);
// front operations shift the whole chain one place, back operations touch
// only the cell at or just past the end of the occupied run.
// The chain updates when the input beat is taken; the result register is then
// loaded, with the back word gathered from the cells. No new operation is
// taken while one is still pending.
// A push on a full queue or a pop on an empty one is refused, flagged and
// changes nothing. Undefined modes leave the state alone without error.
// Reset empties the queue at once; no clearing pass is needed.
// When the sink stalls, the result holds in the output register and no new
// operation is taken until it drains (the next one may enter in the cycle
// the result is taken).
module bounded_deque
  import bdq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
)(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // mode[2:0], value[34:3], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata    // front_value[31:0], back_value[63:32],
                                      // count[68:64], is_empty[69], op_error[70]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                     s_beat;
  logic [MODE_W-1:0]        mode;
  logic signed [WORD_W-1:0] value;
  logic                     full;
  logic                     empty;
  cmd_t                     cmd;
  logic                     err_now;

  logic                     pend;
  logic                     err;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  logic signed [WORD_W-1:0] cell_data [CAPACITY];
  logic                     cell_occ  [CAPACITY];

  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] back_value;
  logic [COUNT_W-1:0]       count_out;
  logic                     is_empty;
  logic                     op_error;
  logic signed [WORD_W-1:0] back_gather;

  assign mode  = s_tdata[MODE_W-1:0];
  assign value = s_tdata[MODE_W+WORD_W-1:MODE_W];
  assign full  = cell_occ[CAPACITY-1];
  assign empty = !cell_occ[0];

  assign s_tready = !pend && (!m_tvalid || m_tready);
  assign s_beat   = s_tvalid && s_tready;

  // decode; refused operations turn into a hold
  always_comb begin
    cmd     = '0;
    err_now = 1'b0;
    case (mode)
      MODE_PUSH_BACK: begin
        err_now      = full;
        cmd.add_back = s_beat && !full;
      end
      MODE_PUSH_FRONT: begin
        err_now       = full;
        cmd.add_front = s_beat && !full;
      end
      MODE_POP_BACK: begin
        err_now       = empty;
        cmd.take_back = s_beat && !empty;
      end
      MODE_POP_FRONT: begin
        err_now        = empty;
        cmd.take_front = s_beat && !empty;
      end
      MODE_CLEAR: begin
        cmd.clear = s_beat;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (cmd.add_back || cmd.add_front) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.take_back || cmd.take_front) begin
      count_next = count - CNT_W'(1);
    end else if (cmd.clear) begin
      count_next = '0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] l_data;
    logic                     l_occ;
    logic signed [WORD_W-1:0] r_data;
    logic                     r_occ;

    if (i == 0) begin : g_first
      assign l_data = value;
      assign l_occ  = 1'b1;
    end else begin : g_mid_l
      assign l_data = cell_data[i-1];
      assign l_occ  = cell_occ[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_data = '0;
      assign r_occ  = 1'b0;
    end else begin : g_mid_r
      assign r_data = cell_data[i+1];
      assign r_occ  = cell_occ[i+1];
    end

    bdq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .value      (value),
      .left_data  (l_data),
      .left_occ   (l_occ),
      .right_data (r_data),
      .right_occ  (r_occ),
      .data       (cell_data[i]),
      .occ        (cell_occ[i])
    );
  end

  // back word: the one cell that ends the occupied run drives the bus
  always_comb begin
    back_gather = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_occ[i] && (i == CAPACITY - 1 || !cell_occ[(i + 1) % CAPACITY])) begin
        back_gather = back_gather | cell_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
      count    <= '0;
    end else begin
      count <= count_next;
      pend  <= s_beat;
      if (pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      err <= err_now;
    end
    if (pend) begin
      front_value <= cell_occ[0] ? cell_data[0] : '0;
      back_value  <= back_gather;
      count_out   <= COUNT_W'(count);
      is_empty    <= !cell_occ[0];
      op_error    <= err;
    end
  end

  assign m_tdata = {1'b0, op_error, is_empty, count_out, back_value, front_value};

endmodule

`default_nettype wire
